/* sv/crcfr_pkg.sv */
package crcfr_pkg;

    // frame delimiters
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hCC;
    localparam logic [7:0] TAIL_BYTE  = 8'h55;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // result status codes
    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_READ   = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4,
        PH_TAIL    = 3'd5
    } t_phase;

    // one 32-bit word step, msb first; the loop folds into a fixed xor network
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 32; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* sv/crcfr_ram.sv */
module crcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/crc_checked_frame_receiver.sv */
// pipeline: a result passes through the payload ram read stage and then
// the output register before it is presented
// throughput: one item per cycle, as long as the output side keeps up
// reset: i_rst_n is synchronous, active low; the receiver returns to hunting,
// the confirmed length clears and both pipeline stages empty; ram contents are kept
module crc_checked_frame_receiver
    import crcfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  logic        s_axis_tuser,   // [0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] frame_length, [15:8] read_data,
                                        // [16] read_valid, [23:17] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    // input field split
    logic       w_mode;
    logic [7:0] w_rx_byte;
    logic [7:0] w_read_index;
    logic       w_in_xfer;

    assign w_mode       = s_axis_tuser;
    assign w_rx_byte    = s_axis_tdata[7:0];
    assign w_read_index = s_axis_tdata[15:8];
    assign w_in_xfer    = s_axis_tvalid && s_axis_tready;

    // receiver state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_exp_len, n_exp_len;
    logic [7:0]  r_byte_cnt, n_byte_cnt;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_rx_crc, n_rx_crc;
    logic [7:0]  r_conf_len, n_conf_len;
    // the payload lives in two banks: one holds the confirmed frame, the
    // other takes the frame being received; a good frame just swaps roles
    logic        r_conf_bank, n_conf_bank;

    // per-item result before the ram read
    logic [1:0]  w_status;
    logic        w_rvalid;
    logic        w_buf_we;

    // pipeline stages
    logic        r_s1_valid;
    logic [1:0]  r_s1_status;
    logic [7:0]  r_s1_len;
    logic        r_s1_rvalid;
    logic        r_s1_bank;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [7:0]  r_out_len;
    logic [7:0]  r_out_rdata;
    logic        r_out_rvalid;
    logic        w_advance;

    logic [7:0]  w_rdata [2];

    // next phase of the frame hunter
    always_comb begin
        n_phase = r_phase;
        if (w_in_xfer && !w_mode) begin
            unique case (r_phase)
                PH_HUNT:    n_phase = (w_rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
                PH_HDR2:    n_phase = (w_rx_byte == HDR_SECOND) ? PH_LEN : PH_HUNT;
                PH_LEN:     n_phase = (w_rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
                PH_PAYLOAD: n_phase = (r_byte_cnt + 8'd1 == r_exp_len) ? PH_CRC : PH_PAYLOAD;
                PH_CRC:     n_phase = (r_byte_cnt + 8'd1 >= 8'd4) ? PH_TAIL : PH_CRC;
                PH_TAIL:    n_phase = PH_HUNT;
                default:    n_phase = PH_HUNT;
            endcase
        end
    end

    // datapath updates and the result of each transfer
    always_comb begin
        n_exp_len   = r_exp_len;
        n_byte_cnt  = r_byte_cnt;
        n_crc       = r_crc;
        n_rx_crc    = r_rx_crc;
        n_conf_len  = r_conf_len;
        n_conf_bank = r_conf_bank;
        w_status    = ST_BUSY;
        w_rvalid    = 1'b0;
        w_buf_we    = 1'b0;
        if (w_in_xfer) begin
            if (w_mode) begin
                // read request: answered from the confirmed bank, state untouched
                w_status = ST_READ;
                w_rvalid = (w_read_index < r_conf_len)
                        && ({1'b0, w_read_index} < 9'(BUFFER_DEPTH));
            end else begin
                unique case (r_phase) inside
                    PH_HUNT, PH_HDR2: begin
                    end
                    PH_LEN: begin
                        n_exp_len  = w_rx_byte;
                        n_byte_cnt = 8'd0;
                        n_rx_crc   = 32'd0;
                        n_crc      = crc_word(CRC_INIT, w_rx_byte);
                    end
                    PH_PAYLOAD: begin
                        // positions past the buffer are dropped but still checked
                        w_buf_we   = ({1'b0, r_byte_cnt} < 9'(BUFFER_DEPTH));
                        n_crc      = crc_word(r_crc, w_rx_byte);
                        n_byte_cnt = (r_byte_cnt + 8'd1 == r_exp_len) ? 8'd0
                                                                      : r_byte_cnt + 8'd1;
                    end
                    PH_CRC: begin
                        // crc arrives least significant byte first
                        n_rx_crc   = r_rx_crc | ({24'd0, w_rx_byte} << {r_byte_cnt[1:0], 3'b000});
                        n_byte_cnt = (r_byte_cnt + 8'd1 >= 8'd4) ? 8'd0 : r_byte_cnt + 8'd1;
                    end
                    PH_TAIL: begin
                        if (r_rx_crc == r_crc && w_rx_byte == TAIL_BYTE) begin
                            n_conf_len  = r_exp_len;
                            n_conf_bank = ~r_conf_bank;
                            w_status    = ST_ACCEPT;
                        end else begin
                            w_status = ST_REJECT;
                        end
                        n_byte_cnt = 8'd0;
                    end
                    default: begin
                        n_byte_cnt = 8'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_exp_len   <= 8'd0;
            r_byte_cnt  <= 8'd0;
            r_crc       <= CRC_INIT;
            r_rx_crc    <= 32'd0;
            r_conf_len  <= 8'd0;
            r_conf_bank <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_exp_len   <= n_exp_len;
            r_byte_cnt  <= n_byte_cnt;
            r_crc       <= n_crc;
            r_rx_crc    <= n_rx_crc;
            r_conf_len  <= n_conf_len;
            r_conf_bank <= n_conf_bank;
        end
    end

    // payload banks; the receive bank is always the one not confirmed
    for (genvar g = 0; g < 2; g++) begin : g_bank
        crcfr_ram #(
            .WIDTH (8),
            .DEPTH (BUFFER_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_buf_we && (r_conf_bank != 1'(g))),
            .i_waddr (r_byte_cnt[AW-1:0]),
            .i_wdata (w_rx_byte),
            .i_re    (w_in_xfer),
            .i_raddr (w_read_index[AW-1:0]),
            .o_rdata (w_rdata[g])
        );
    end

    // two-stage pipeline: ram read stage, then output register; the ram read
    // register only loads on an input transfer, so it holds while stage one stalls
    assign w_advance     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_status <= w_status;
            r_s1_len    <= n_conf_len;
            r_s1_rvalid <= w_rvalid;
            r_s1_bank   <= r_conf_bank;
        end
        if (w_advance) begin
            r_out_status <= r_s1_status;
            r_out_len    <= r_s1_len;
            r_out_rvalid <= r_s1_rvalid;
            r_out_rdata  <= r_s1_rvalid ? w_rdata[r_s1_bank] : 8'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {7'd0, r_out_rvalid, r_out_rdata, r_out_len};

endmodule

/* sv/crcfr_checker.sv */
module crcfr_checker
    import crcfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a waiting input transfer holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("waiting input transfer changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // only read replies carry read data
    a_no_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_READ |-> m_axis_tdata[16:8] == 9'd0)
        else $error("read fields set on a non-read result");

    // an invalid read returns zero
    a_invalid_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_READ && !m_axis_tdata[16]
            |-> m_axis_tdata[15:8] == 8'd0)
        else $error("invalid read returned data");

    // a valid read needs a confirmed frame with payload
    a_valid_read_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_READ && m_axis_tdata[16]
            |-> m_axis_tdata[7:0] != 8'd0)
        else $error("valid read with empty confirmed frame");

endmodule

bind crc_checked_frame_receiver crcfr_checker u_crcfr_checker (.*);
